/* sv/tpgs_pkg.sv */
package tpgs_pkg;

  // Fixed field widths and structure of the smoother
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned NUM_COORD   = 3;
  localparam int unsigned TAPS        = 5;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned EDGE_POINTS = 2;
  localparam int unsigned COUNT_FULL  = 5;
  localparam int unsigned SEEN_W      = 3;

  // Result queue geometry (depth is a power of two so the pointers wrap)
  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_PTR_W = 3;
  localparam int unsigned OQ_CNT_W = 4;

  // Register reset values, unsigned Q0.16 at the default weight width
  localparam int unsigned RST_WEIGHT_CENTER = 26386;
  localparam int unsigned RST_WEIGHT_NEAR   = 16004;
  localparam int unsigned RST_WEIGHT_FAR    = 3571;

  // Register map, word index taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_WEIGHT_CENTER = 2'd0,
    REG_WEIGHT_NEAR   = 2'd1,
    REG_WEIGHT_FAR    = 2'd2
  } tpgs_reg_e;

  // Which results one accepted point produces
  typedef struct packed {
    logic emit0;    // point two places back, smoothed or raw
    logic smooth0;  // full window present for that point
    logic emit1;    // end of track: previous point raw
    logic emit2;    // end of track: this point raw, last of run
  } tpgs_flags_t;

  // Number of result words a point produces
  function automatic logic [1:0] result_count(tpgs_flags_t f);
    logic [1:0] n;
    n = 2'({1'b0, f.emit0} + {1'b0, f.emit1} + {1'b0, f.emit2});
    return n;
  endfunction

endpackage

/* sv/tpgs_window.sv */
module tpgs_window #(
  parameter int unsigned COORD_WIDTH = 48
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    acc_i,
  input  logic [2:0][COORD_WIDTH-1:0]             pos_i,
  input  logic [tpgs_pkg::TIME_W-1:0]             time_i,
  input  logic                                    end_i,
  output logic                                    valid_o,
  output tpgs_pkg::tpgs_flags_t                   flags_o,
  output logic [2:0][4:0][COORD_WIDTH-1:0]        win_o,
  output logic [2:0][tpgs_pkg::TIME_W-1:0]        time_o
);

  logic [2:0][3:0][COORD_WIDTH-1:0]         hist_q;
  logic [1:0][tpgs_pkg::TIME_W-1:0]         hist_time_q;
  logic [tpgs_pkg::SEEN_W-1:0]              seen_q, seen_d, seen_next;
  logic                                     valid_q;
  tpgs_pkg::tpgs_flags_t                    flags_q, flags_d;
  logic [2:0][4:0][COORD_WIDTH-1:0]         win_q, win_d;
  logic [2:0][tpgs_pkg::TIME_W-1:0]         time_q, time_d;

  // Decide what this point releases and advance the track count
  always_comb begin
    if (seen_q >= tpgs_pkg::SEEN_W'(tpgs_pkg::COUNT_FULL)) begin
      seen_next = tpgs_pkg::SEEN_W'(tpgs_pkg::COUNT_FULL);
    end else begin
      seen_next = seen_q + tpgs_pkg::SEEN_W'(1);
    end
    flags_d.emit0   = seen_q >= tpgs_pkg::SEEN_W'(tpgs_pkg::EDGE_POINTS);
    flags_d.smooth0 = seen_q >= tpgs_pkg::SEEN_W'(2 * tpgs_pkg::EDGE_POINTS);
    flags_d.emit1   = end_i && (seen_next >= tpgs_pkg::SEEN_W'(tpgs_pkg::EDGE_POINTS));
    flags_d.emit2   = end_i;
    seen_d          = end_i ? '0 : seen_next;
  end

  // Window: far before, near before, centre, near after, far after (the new point)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k] = {pos_i[k], hist_q[k][0], hist_q[k][1], hist_q[k][2], hist_q[k][3]};
    end
    time_d = {time_i, hist_time_q[0], hist_time_q[1]};
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      seen_q  <= '0;
    end else begin
      valid_q <= acc_i;
      if (acc_i) begin
        seen_q <= seen_d;
      end
    end
  end

  // Shift the raw history and capture the window on each accepted word
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      for (int k = 0; k < 3; k++) begin
        hist_q[k] <= {hist_q[k][2:0], pos_i[k]};
      end
      hist_time_q <= {hist_time_q[0], time_i};
      win_q       <= win_d;
      time_q      <= time_d;
      flags_q     <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign win_o   = win_q;
  assign time_o  = time_q;

endmodule

/* sv/tpgs_filter.sv */
module tpgs_filter #(
  parameter int unsigned COORD_WIDTH = 48,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic [4:0][COORD_WIDTH-1:0]   win_i,
  input  logic [WEIGHT_BITS-1:0]        weight_center_i,
  input  logic [WEIGHT_BITS-1:0]        weight_near_i,
  input  logic [WEIGHT_BITS-1:0]        weight_far_i,
  output logic [COORD_WIDTH-1:0]        smooth_o
);

  localparam int unsigned PW = COORD_WIDTH + WEIGHT_BITS + 1;
  localparam int unsigned SW = PW + 3;
  localparam int unsigned HW = SW - WEIGHT_BITS;

  logic [4:0][WEIGHT_BITS-1:0] tap_w;
  logic [4:0][PW-1:0]          prod_d, prod_q;
  logic signed [PW-1:0]        coord_ext, weight_ext;
  logic signed [SW-1:0]        sum;
  logic [HW-1:0]               shifted;
  logic [4:0]                  top_bits;
  logic                        neg;

  // Symmetric kernel: far, near, centre, near, far
  assign tap_w = {weight_far_i, weight_near_i, weight_center_i, weight_near_i, weight_far_i};

  // One product per tap, registered
  always_comb begin
    prod_d = '0;
    for (int k = 0; k < 5; k++) begin
      coord_ext  = PW'($signed(win_i[k]));
      weight_ext = $signed(PW'(tap_w[k]));
      prod_d[k]  = coord_ext * weight_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Sum, drop the weight fraction, saturate to the coordinate range
  always_comb begin
    sum = '0;
    for (int k = 0; k < 5; k++) begin
      sum = sum + SW'($signed(prod_q[k]));
    end
    neg      = sum[SW-1];
    shifted  = sum[SW-1:WEIGHT_BITS];
    top_bits = shifted[HW-1:COORD_WIDTH-1];
    if ((top_bits == '0) || (top_bits == '1)) begin
      smooth_o = shifted[COORD_WIDTH-1:0];
    end else if (neg) begin
      smooth_o = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      smooth_o = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  end

endmodule

/* sv/tpgs_out_fifo.sv */
module tpgs_out_fifo #(
  parameter int unsigned WIDTH = 177
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        wr_cnt_i,
  input  logic [2:0][WIDTH-1:0]             wr_data_i,
  input  logic                              rd_stall_i,
  output logic                              rd_valid_o,
  output logic [WIDTH-1:0]                  rd_data_o,
  output logic [tpgs_pkg::OQ_CNT_W-1:0]     count_o
);

  logic [WIDTH-1:0]                   mem_q [tpgs_pkg::OQ_DEPTH];
  logic [tpgs_pkg::OQ_PTR_W-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tpgs_pkg::OQ_CNT_W-1:0]      count_q, count_d;
  logic                               pop;

  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign pop        = rd_valid_o && !rd_stall_i;
  assign count_o    = count_q;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + tpgs_pkg::OQ_PTR_W'(wr_cnt_i);
    rd_ptr_d = rd_ptr_q + tpgs_pkg::OQ_PTR_W'(pop);
    count_d  = count_q + tpgs_pkg::OQ_CNT_W'(wr_cnt_i) - tpgs_pkg::OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store up to three words in consecutive slots
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (k < int'(wr_cnt_i)) begin
        mem_q[wr_ptr_q + tpgs_pkg::OQ_PTR_W'(k)] <= wr_data_i[k];
      end
    end
  end

endmodule

/* sv/track_point_gaussian_smoother_unit.sv */
// Channel | Direction | Handshake                        | Payload
// in      | input     | in_valid_i / in_stall_o          | pos_x/y/z_i, time_delta_i, end_of_track_i
// out     | output    | out_valid_o / out_stall_i        | out_x/y/z_o, out_time_o, last_of_run_o
// cfg     | input     | psel/penable/pwrite/pready (APB) | paddr, pwdata, prdata
//
// One point is taken per cycle while in_stall_o is low; its first result word is presented after the point
// has passed the window register, the product register and then the eight-entry result queue.
// An end-of-track point releases up to three words, drained from the queue one per cycle while out_stall_i is low.
// in_stall_o rises when the queue plus the words in flight leave no room for three more.
// Reset clears the track count and the queue and loads the default weights; no clearing
// pass is needed.
module track_point_gaussian_smoother_unit #(
  parameter int unsigned COORD_WIDTH = 48,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // point input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [COORD_WIDTH-1:0]            pos_x_i,
  input  logic [COORD_WIDTH-1:0]            pos_y_i,
  input  logic [COORD_WIDTH-1:0]            pos_z_i,
  input  logic [tpgs_pkg::TIME_W-1:0]       time_delta_i,
  input  logic                              end_of_track_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [COORD_WIDTH-1:0]            out_x_o,
  output logic [COORD_WIDTH-1:0]            out_y_o,
  output logic [COORD_WIDTH-1:0]            out_z_o,
  output logic [tpgs_pkg::TIME_W-1:0]       out_time_o,
  output logic                              last_of_run_o,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned TW    = tpgs_pkg::TIME_W;
  localparam int unsigned EW    = 3 * COORD_WIDTH + TW + 1;
  localparam int unsigned OCC_W = tpgs_pkg::OQ_CNT_W + 1;

  logic [WEIGHT_BITS-1:0]             w_center_q, w_near_q, w_far_q;
  logic                               cfg_wr;
  tpgs_pkg::tpgs_reg_e                reg_idx;

  logic                               in_acc;
  logic [2:0][COORD_WIDTH-1:0]        pos_in;

  logic                               s0_valid;
  tpgs_pkg::tpgs_flags_t              s0_flags;
  logic [2:0][4:0][COORD_WIDTH-1:0]   s0_win;
  logic [2:0][TW-1:0]                 s0_time;

  logic                               s1_valid_q;
  tpgs_pkg::tpgs_flags_t              s1_flags_q;
  logic [2:0][2:0][COORD_WIDTH-1:0]   s1_raw_q, s1_raw_d;
  logic [2:0][TW-1:0]                 s1_time_q;
  logic [2:0][COORD_WIDTH-1:0]        smooth;

  logic [2:0][COORD_WIDTH-1:0]        r0_coord, r1_coord, r2_coord;
  logic [EW-1:0]                      r0, r1, r2;
  logic [2:0][EW-1:0]                 wr_data;
  logic [1:0]                         wr_cnt;
  logic [EW-1:0]                      rd_data;
  logic [tpgs_pkg::OQ_CNT_W-1:0]      q_count;
  logic [1:0]                         pend0, pend1;
  logic [OCC_W-1:0]                   occupancy;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = tpgs_pkg::tpgs_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_center_q <= WEIGHT_BITS'(tpgs_pkg::RST_WEIGHT_CENTER);
      w_near_q   <= WEIGHT_BITS'(tpgs_pkg::RST_WEIGHT_NEAR);
      w_far_q    <= WEIGHT_BITS'(tpgs_pkg::RST_WEIGHT_FAR);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tpgs_pkg::REG_WEIGHT_CENTER: w_center_q <= pwdata[WEIGHT_BITS-1:0];
        tpgs_pkg::REG_WEIGHT_NEAR:   w_near_q   <= pwdata[WEIGHT_BITS-1:0];
        tpgs_pkg::REG_WEIGHT_FAR:    w_far_q    <= pwdata[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tpgs_pkg::REG_WEIGHT_CENTER: prdata = 32'(w_center_q);
      tpgs_pkg::REG_WEIGHT_NEAR:   prdata = 32'(w_near_q);
      tpgs_pkg::REG_WEIGHT_FAR:    prdata = 32'(w_far_q);
      default:                     prdata = '0;
    endcase
  end

  // Admission: hold off while the queue could not take three more words
  always_comb begin
    pend0     = s0_valid ? tpgs_pkg::result_count(s0_flags) : 2'd0;
    pend1     = s1_valid_q ? tpgs_pkg::result_count(s1_flags_q) : 2'd0;
    occupancy = OCC_W'(q_count) + OCC_W'(pend0) + OCC_W'(pend1);
  end

  assign in_stall_o = occupancy > OCC_W'(tpgs_pkg::OQ_DEPTH - tpgs_pkg::MAX_RESULTS);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_in     = {pos_z_i, pos_y_i, pos_x_i};

  tpgs_window #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (in_acc),
    .pos_i   (pos_in),
    .time_i  (time_delta_i),
    .end_i   (end_of_track_i),
    .valid_o (s0_valid),
    .flags_o (s0_flags),
    .win_o   (s0_win),
    .time_o  (s0_time)
  );

  // Smoothing lanes, one per coordinate
  for (genvar g = 0; g < 3; g++) begin : g_lane
    tpgs_filter #(
      .COORD_WIDTH (COORD_WIDTH),
      .WEIGHT_BITS (WEIGHT_BITS)
    ) u_filter (
      .clk_i           (clk_i),
      .win_i           (s0_win[g]),
      .weight_center_i (w_center_q),
      .weight_near_i   (w_near_q),
      .weight_far_i    (w_far_q),
      .smooth_o        (smooth[g])
    );
  end

  // Carry raw centre, near-after and new point alongside the products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_raw_d[k] = {s0_win[k][4], s0_win[k][3], s0_win[k][2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s0_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_flags_q <= s0_flags;
    s1_raw_q   <= s1_raw_d;
    s1_time_q  <= s0_time;
  end

  // Build the result words and pack them densely for the queue
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r0_coord[k] = s1_flags_q.smooth0 ? smooth[k] : s1_raw_q[k][0];
      r1_coord[k] = s1_raw_q[k][1];
      r2_coord[k] = s1_raw_q[k][2];
    end
    r0 = {1'b0, s1_time_q[0], r0_coord};
    r1 = {1'b0, s1_time_q[1], r1_coord};
    r2 = {1'b1, s1_time_q[2], r2_coord};
    wr_data[0] = s1_flags_q.emit0 ? r0 : (s1_flags_q.emit1 ? r1 : r2);
    wr_data[1] = s1_flags_q.emit0 ? (s1_flags_q.emit1 ? r1 : r2) : r2;
    wr_data[2] = r2;
    wr_cnt     = s1_valid_q ? tpgs_pkg::result_count(s1_flags_q) : 2'd0;
  end

  tpgs_out_fifo #(
    .WIDTH (EW)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cnt_i   (wr_cnt),
    .wr_data_i  (wr_data),
    .rd_stall_i (out_stall_i),
    .rd_valid_o (out_valid_o),
    .rd_data_o  (rd_data),
    .count_o    (q_count)
  );

  // Unpack the head word
  assign out_x_o       = rd_data[COORD_WIDTH-1:0];
  assign out_y_o       = rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
  assign out_z_o       = rd_data[3*COORD_WIDTH-1:2*COORD_WIDTH];
  assign out_time_o    = rd_data[3*COORD_WIDTH+TW-1:3*COORD_WIDTH];
  assign last_of_run_o = rd_data[EW-1];

  // Checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= tpgs_pkg::OQ_CNT_W'(tpgs_pkg::OQ_DEPTH))
    else $error("result queue overfilled");

  a_accept_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s0_valid)
    else $error("accepted word did not reach the window register");

  a_flush_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_flags_q.emit1) |-> s1_flags_q.emit2)
    else $error("flush of previous point without the final point");

  a_smooth_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_flags_q.smooth0) |-> s1_flags_q.emit0)
    else $error("smoothed point without a release");

endmodule
